>>> hdl/tets_pkg.sv
package tets_pkg;

    localparam logic [7:0] BYTE_NL  = 8'h0A;
    localparam logic [7:0] BYTE_SP  = 8'h20;
    localparam logic [7:0] BYTE_TAB = 8'h09;

    // Tab stops fall on every fourth column.
    localparam logic [2:0] TAB_STOP = 3'd4;

    localparam int SPACE_COUNT_BITS = 16;

    typedef enum logic [1:0] {
        K_NEWLINE,
        K_SPACE,
        K_TAB,
        K_OTHER
    } t_kind;

    // One classified byte, as handed from the front end to the back end.
    typedef struct packed {
        t_kind      kind;
        logic [2:0] inc;
        logic [7:0] data;
        logic       eof;
    } t_cmd;

    typedef struct packed {
        logic [SPACE_COUNT_BITS-1:0] space_count;
        logic [7:0]                  out_byte;
        logic                        byte_present;
        logic                        stream_end;
        logic                        run_overflow;
    } t_result;

endpackage

>>> hdl/tets_ifs.sv
interface tets_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_file;

    modport source (output valid, output in_byte, output end_of_file, input ready);
    modport sink   (input valid, input in_byte, input end_of_file, output ready);
endinterface

interface tets_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] space_count;
    logic [7:0]  out_byte;
    logic        byte_present;
    logic        stream_end;
    logic        run_overflow;

    modport source (output valid, output space_count, output out_byte,
                    output byte_present, output stream_end, output run_overflow,
                    input ready);
    modport sink   (input valid, input space_count, input out_byte,
                    input byte_present, input stream_end, input run_overflow,
                    output ready);
endinterface

>>> hdl/tets_front.sv
module tets_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tets_in_if.sink        i_in,
    input  logic           i_q_full,
    output logic           o_push,
    output tets_pkg::t_cmd o_cmd
);

    logic [1:0]      r_phase;
    logic [1:0]      n_phase;
    tets_pkg::t_kind kind;

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    always_comb begin
        priority if (i_in.in_byte == tets_pkg::BYTE_NL) begin
            kind = tets_pkg::K_NEWLINE;
        end else if (i_in.in_byte == tets_pkg::BYTE_SP) begin
            kind = tets_pkg::K_SPACE;
        end else if (i_in.in_byte == tets_pkg::BYTE_TAB) begin
            kind = tets_pkg::K_TAB;
        end else begin
            kind = tets_pkg::K_OTHER;
        end
    end

    // The column only depends on the bytes seen, so it is tracked here and the
    // tab width travels with the transaction.
    always_comb begin
        o_cmd.kind = kind;
        o_cmd.data = i_in.in_byte;
        o_cmd.eof  = i_in.end_of_file;
        o_cmd.inc  = 3'd1;
        n_phase    = r_phase + 2'd1;
        unique case (kind)
            tets_pkg::K_NEWLINE: begin
                n_phase = 2'd0;
            end
            tets_pkg::K_TAB: begin
                o_cmd.inc = tets_pkg::TAB_STOP - {1'b0, r_phase};
                n_phase   = 2'd0;
            end
            default: begin
            end
        endcase
        if (i_in.end_of_file) begin
            n_phase = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
        end else if (o_push) begin
            r_phase <= n_phase;
        end
    end

endmodule

>>> hdl/tets_queue.sv
module tets_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tets_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output tets_pkg::t_cmd o_cmd
);

    tets_pkg::t_cmd r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop)
        else $error("pop from empty queue");

endmodule

>>> hdl/tets_back.sv
module tets_back #(
    parameter int RUN_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  tets_pkg::t_cmd i_cmd,
    output logic           o_pop,
    tets_out_if.source     o_out
);

    localparam int PEND_BITS = (RUN_BITS < tets_pkg::SPACE_COUNT_BITS) ?
                               RUN_BITS : tets_pkg::SPACE_COUNT_BITS;
    localparam logic [PEND_BITS-1:0] RUN_LIMIT = {PEND_BITS{1'b1}};

    logic [PEND_BITS-1:0] r_pend;
    logic [PEND_BITS-1:0] n_pend;
    logic                 r_changed;
    logic                 n_changed;
    logic                 r_ovf;
    logic                 n_ovf;
    logic                 r_valid;
    tets_pkg::t_result    r_res;
    tets_pkg::t_result    n_res;
    logic                 produces;
    logic                 can_load;
    logic [PEND_BITS:0]   sum;

    assign can_load = !r_valid || o_out.ready;
    // A space or tab in mid-file yields nothing and can drain even while stalled.
    assign o_pop    = i_q_valid && (can_load || !produces);
    assign sum      = {1'b0, r_pend} + (PEND_BITS+1)'(i_cmd.inc);

    always_comb begin
        n_pend    = r_pend;
        n_changed = r_changed;
        n_ovf     = r_ovf;
        produces  = 1'b1;
        n_res     = '0;
        unique case (i_cmd.kind)
            tets_pkg::K_NEWLINE: begin
                if (r_pend != '0) begin
                    n_changed = 1'b1;
                end
                n_pend             = '0;
                n_res.out_byte     = tets_pkg::BYTE_NL;
                n_res.byte_present = 1'b1;
            end
            tets_pkg::K_SPACE, tets_pkg::K_TAB: begin
                produces = i_cmd.eof;
                if (sum[PEND_BITS]) begin
                    n_pend = RUN_LIMIT;
                    n_ovf  = 1'b1;
                end else begin
                    n_pend = sum[PEND_BITS-1:0];
                end
                if (i_cmd.kind == tets_pkg::K_TAB) begin
                    n_changed = 1'b1;
                end
                // A run left at end of file becomes a newline once the file changed.
                if (n_changed) begin
                    n_res.out_byte     = tets_pkg::BYTE_NL;
                    n_res.byte_present = 1'b1;
                end else begin
                    n_res.space_count = tets_pkg::SPACE_COUNT_BITS'(n_pend);
                end
            end
            tets_pkg::K_OTHER: begin
                n_res.space_count  = tets_pkg::SPACE_COUNT_BITS'(r_pend);
                n_res.out_byte     = i_cmd.data;
                n_res.byte_present = 1'b1;
                n_pend             = '0;
            end
            default: begin
            end
        endcase
        n_res.stream_end   = i_cmd.eof;
        n_res.run_overflow = n_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= '0;
            r_changed <= 1'b0;
            r_ovf     <= 1'b0;
        end else if (o_pop) begin
            if (i_cmd.eof) begin
                r_pend    <= '0;
                r_changed <= 1'b0;
                r_ovf     <= 1'b0;
            end else begin
                r_pend    <= n_pend;
                r_changed <= n_changed;
                r_ovf     <= n_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (can_load) begin
            r_valid <= o_pop && produces;
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_load && o_pop && produces) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.space_count  = r_res.space_count;
    assign o_out.out_byte     = r_res.out_byte;
    assign o_out.byte_present = r_res.byte_present;
    assign o_out.stream_end   = r_res.stream_end;
    assign o_out.run_overflow = r_res.run_overflow;

    a_eof_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_cmd.eof) |=> (r_pend == '0 && !r_changed && !r_ovf))
        else $error("file state not cleared after end of file");

    a_spaces_only_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_res.byte_present) |-> (r_res.out_byte == '0 && r_res.stream_end))
        else $error("spaces-only result outside end of file");

    a_newline_no_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.byte_present && r_res.out_byte == tets_pkg::BYTE_NL)
        |-> (r_res.space_count == '0))
        else $error("newline carries a space run");

    a_no_silent_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && produces) |-> can_load)
        else $error("result consumed while output register busy");

endmodule

>>> hdl/tab_expand_trailing_space_strip_top.sv
// An accepted transaction is written into the queue and then into the output register,
// which holds its result until the output side is ready.
// Throughput: one byte per cycle while the output is ready; during output stalls the
// two-entry queue fills and holds input back; mid-file spaces and tabs still drain.
// Reset (synchronous, active low) empties the queue and output register and clears the
// column phase, pending run, changed flag and overflow flag.
module tab_expand_trailing_space_strip_top #(
    parameter int RUN_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tets_in_if.sink    i_in,
    tets_out_if.source o_out
);

    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_valid;
    tets_pkg::t_cmd front_cmd;
    tets_pkg::t_cmd q_cmd;

    tets_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    tets_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    tets_back #(
        .RUN_BITS (RUN_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (q_cmd),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

>>> test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_BITS = 16;
    localparam int unsigned RUN_MAX = (RUN_BITS >= 16) ? 32'hFFFF : (32'd1 << RUN_BITS) - 1;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int ITEMS_PER_PHASE = 440;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tets_in_if  in_if ();
    tets_out_if out_if ();

    tab_expand_trailing_space_strip_top #(
        .RUN_BITS (RUN_BITS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #10 i_clk = ~i_clk;

    // Shadow of the block's per-file state.
    logic [1:0]  col_phase = '0;
    int unsigned run_len = 0;
    logic        file_dirty = 1'b0;
    logic        run_sat = 1'b0;

    tets_pkg::t_result stripped_q[$];
    int      items_sent = 0;
    int      fail_count = 0;
    int      sender_idle_pct = 0;
    int      receiver_stall_pct = 0;
    int      cycle_count = 0;

    function automatic void clear_file_state();
        col_phase  = '0;
        run_len    = 0;
        file_dirty = 1'b0;
        run_sat    = 1'b0;
    endfunction

    function automatic void grow_run(input int unsigned n);
        if (run_len + n > RUN_MAX) begin
            run_len = RUN_MAX;
            run_sat = 1'b1;
        end else begin
            run_len = run_len + n;
        end
    endfunction

    function automatic void predict_stripped_output(input logic [7:0] b, input logic eof);
        tets_pkg::t_result r;
        bit                have;
        tets_pkg::t_kind   kind;
        r    = '0;
        have = 1'b0;
        case (b)
            tets_pkg::BYTE_NL:  kind = tets_pkg::K_NEWLINE;
            tets_pkg::BYTE_SP:  kind = tets_pkg::K_SPACE;
            tets_pkg::BYTE_TAB: kind = tets_pkg::K_TAB;
            default:            kind = tets_pkg::K_OTHER;
        endcase
        case (kind)
            tets_pkg::K_NEWLINE: begin
                // A run in front of a newline is trailing whitespace and is dropped.
                if (run_len != 0)
                    file_dirty = 1'b1;
                run_len        = 0;
                col_phase      = '0;
                r.out_byte     = tets_pkg::BYTE_NL;
                r.byte_present = 1'b1;
                have           = 1'b1;
            end
            tets_pkg::K_SPACE: begin
                grow_run(1);
                col_phase = col_phase + 2'd1;
            end
            tets_pkg::K_TAB: begin
                grow_run(int'(tets_pkg::TAB_STOP) - int'(col_phase));
                col_phase  = '0;
                file_dirty = 1'b1;
            end
            default: begin
                r.space_count  = run_len[15:0];
                r.out_byte     = b;
                r.byte_present = 1'b1;
                run_len        = 0;
                col_phase      = col_phase + 2'd1;
                have           = 1'b1;
            end
        endcase
        r.run_overflow = run_sat;
        r.stream_end   = eof;
        if (eof) begin
            if (!have) begin
                // A changed file loses its trailing run; an untouched one keeps it.
                if (file_dirty) begin
                    r.out_byte     = tets_pkg::BYTE_NL;
                    r.byte_present = 1'b1;
                end else begin
                    r.space_count = run_len[15:0];
                end
                have = 1'b1;
            end
            clear_file_state();
        end
        if (have) begin
            stripped_q.push_back(r);
        end
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        tets_pkg::t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (stripped_q.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual %0h %0h %0b %0b %0b",
                         $time, out_if.space_count, out_if.out_byte, out_if.byte_present,
                         out_if.stream_end, out_if.run_overflow);
                fail_count++;
            end else begin
                want = stripped_q.pop_front();
                check_field("space_count", 32'(want.space_count), 32'(out_if.space_count));
                check_field("out_byte", 32'(want.out_byte), 32'(out_if.out_byte));
                check_field("byte_present", 32'(want.byte_present),
                            32'(out_if.byte_present));
                check_field("stream_end", 32'(want.stream_end), 32'(out_if.stream_end));
                check_field("run_overflow", 32'(want.run_overflow),
                            32'(out_if.run_overflow));
            end
        end
        out_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eof);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.in_byte     <= b;
        in_if.end_of_file <= eof;
        do
            @(posedge i_clk);
        while (!in_if.ready);
        items_sent++;
        predict_stripped_output(b, eof);
    endtask

    task automatic send_text(input string s, input bit eof_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eof_last && (i == s.len() - 1));
    endtask

    task automatic test_byte_extremes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte("x", 1'b1);
    endtask

    // Tabs from every column phase, so each stop width from four down to one is used.
    task automatic test_tab_stops();
        send_text("\ta\tbc\tefg\th\n", 1'b1);
    endtask

    task automatic test_dropped_run();
        send_text("  \n ", 1'b1);
    endtask

    task automatic test_clean_file_end();
        send_text("z  ", 1'b1);
    endtask

    // Saturation by spaces alone leaves the file unchanged, so the final run survives.
    task automatic test_run_saturation();
        for (int unsigned i = 0; i <= RUN_MAX; i++)
            send_byte(tets_pkg::BYTE_SP, 1'b0);
        send_text("ab ", 1'b1);
    endtask

    function automatic logic [7:0] random_text_byte();
        int pick;
        pick = $urandom_range(99);
        if (pick < 35)
            return 8'($urandom_range(8'h7E, 8'h21));
        else if (pick < 55)
            return tets_pkg::BYTE_SP;
        else if (pick < 68)
            return tets_pkg::BYTE_TAB;
        else if (pick < 78)
            return tets_pkg::BYTE_NL;
        else
            return 8'($urandom_range(255));
    endfunction

    task automatic test_random_text(input int idle_pct, input int stall_pct, input int target);
        int start;
        int len;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        start              = items_sent;
        while (items_sent - start < target) begin
            len = $urandom_range(40, 1);
            for (int i = 0; i < len; i++)
                send_byte(random_text_byte(), i == len - 1);
        end
    endtask

    initial begin
        in_if.valid       = 1'b0;
        in_if.in_byte     = '0;
        in_if.end_of_file = 1'b0;
        out_if.ready      = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_byte_extremes();
        test_tab_stops();
        test_dropped_run();
        test_clean_file_end();
        test_run_saturation();
        test_random_text(0, 0, ITEMS_PER_PHASE);
        test_random_text(74, 0, ITEMS_PER_PHASE);
        test_random_text(0, 74, ITEMS_PER_PHASE);
        test_random_text(22, 22, ITEMS_PER_PHASE);

        in_if.valid <= 1'b0;
        while (stripped_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
